FILE: src/owi_pkg.sv
// shared types and constants of the occupancy wall inflation block
package owi_pkg;

  localparam int unsigned CFG_DW = 11;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned RADIUS_W = 4;

  localparam int unsigned GRID_WIDTH_RST = 1024;
  localparam int unsigned GRID_HEIGHT_RST = 1024;
  localparam int unsigned INFLATE_RADIUS_RST = 4;

  localparam logic signed [7:0] CELL_WALL = 8'sd100;
  localparam logic signed [7:0] CELL_FREE = 8'sd0;
  localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;
  localparam logic signed [7:0] CELL_INFLATED = -8'sd56;

  typedef enum logic [CFG_IW-1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_GRID_HEIGHT    = 2'd1,
    REG_INFLATE_RADIUS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic              vbit;
    logic signed [7:0] occ;
  } owi_item_t;

endpackage

FILE: src/owi_fifo.sv
// small queue between the front and the back part
module owi_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output logic [WIDTH-1:0]               data_o,
  output logic [$clog2(DEPTH+1)-1:0]     level_o
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LW-1:0]    level_q, level_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (!push_i && pop_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign level_o = level_q;

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && level_q == LW'(DEPTH)))
    else $error("queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && level_q == '0))
    else $error("queue underflow");

endmodule

FILE: src/owi_front.sv
// front part: accepts cells, tracks raster position, keeps line stores and column wall distances
module owi_front #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 1024,
  parameter int unsigned MAX_RADIUS  = 8,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [owi_pkg::CFG_IW-1:0]              cfg_idx_i,
  input  logic [owi_pkg::CFG_DW-1:0]              cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    op_i,
  input  logic signed [7:0]                       cell_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]        q_level_i,
  output logic                                    push_o,
  output owi_pkg::owi_item_t                      item_o,
  output logic [$clog2(MAX_WIDTH)-1:0]            col_o,
  output logic [$clog2(MAX_WIDTH+1)-1:0]          geo_w_o,
  output logic [$clog2(MAX_RADIUS+1)-1:0]         geo_r_o,
  output logic [$clog2(MAX_RADIUS+1)-1:0]         geo_m_o
);
  import owi_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned NR   = MAX_RADIUS + 2;
  localparam int unsigned RRW  = $clog2(NR);
  localparam int unsigned IRW  = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int unsigned IPW  = $clog2((MAX_HEIGHT + MAX_RADIUS + 2) * MAX_WIDTH);
  localparam int unsigned OW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned CNT_SAT = 2 * MAX_RADIUS + 1;
  localparam int unsigned CNTW = $clog2(CNT_SAT + 1);
  localparam int unsigned LW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CDEP = NR * (2 ** CW);
  localparam int unsigned PRW  = WW + HW;

  localparam int unsigned W_RST = (GRID_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RST;
  localparam int unsigned H_RST = (GRID_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : GRID_HEIGHT_RST;
  localparam int unsigned R_RST =
    (INFLATE_RADIUS_RST > MAX_RADIUS) ? MAX_RADIUS : INFLATE_RADIUS_RST;
  localparam int unsigned M_RST = (R_RST < W_RST - 1) ? R_RST : W_RST - 1;
  localparam int unsigned D_RST = R_RST * W_RST + M_RST;
  localparam int unsigned T_RST = W_RST * H_RST - 1;

  // geometry
  logic [WW-1:0]  w_q, w_new, w_sel;
  logic [HW-1:0]  h_q, h_new, h_sel;
  logic [RW-1:0]  r_q, r_new, r_sel, m_q, m_sel;
  logic [IPW-1:0] d_q, d_sel;
  logic [OW-1:0]  totm1_q, totm1_sel;
  logic [PRW-1:0] tot_prod;
  logic [WW+RW-1:0] rw_prod;
  logic           cfg_hit, sel_w, sel_h, sel_r;

  always_comb begin
    sel_w = 1'b0;
    sel_h = 1'b0;
    sel_r = 1'b0;
    unique case (cfg_idx_i)
      REG_GRID_WIDTH:     sel_w = cfg_we_i;
      REG_GRID_HEIGHT:    sel_h = cfg_we_i;
      REG_INFLATE_RADIUS: sel_r = cfg_we_i;
      default: ;
    endcase
  end

  always_comb begin
    if (cfg_data_i == '0) begin
      w_new = WW'(1);
      h_new = HW'(1);
    end else begin
      w_new = (32'(cfg_data_i) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data_i);
      h_new = (32'(cfg_data_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
    end
    r_new = (32'(cfg_data_i[RADIUS_W-1:0]) > MAX_RADIUS) ?
            RW'(MAX_RADIUS) : RW'(cfg_data_i[RADIUS_W-1:0]);
  end

  assign cfg_hit   = sel_w | sel_h | sel_r;
  assign w_sel     = sel_w ? w_new : w_q;
  assign h_sel     = sel_h ? h_new : h_q;
  assign r_sel     = sel_r ? r_new : r_q;
  assign m_sel     = ((WW)'(r_sel) < w_sel - 1'b1) ? r_sel : RW'(w_sel - 1'b1);
  assign rw_prod   = (WW+RW)'(w_sel) * (WW+RW)'(r_sel);
  assign d_sel     = IPW'(rw_prod) + IPW'(m_sel);
  assign tot_prod  = PRW'(w_sel) * PRW'(h_sel);
  assign totm1_sel = OW'(tot_prod - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WW'(W_RST);
      h_q     <= HW'(H_RST);
      r_q     <= RW'(R_RST);
      m_q     <= RW'(M_RST);
      d_q     <= IPW'(D_RST);
      totm1_q <= OW'(T_RST);
    end else if (cfg_hit) begin
      w_q     <= w_sel;
      h_q     <= h_sel;
      r_q     <= r_sel;
      m_q     <= m_sel;
      d_q     <= d_sel;
      totm1_q <= totm1_sel;
    end
  end

  // raster position counters
  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [IRW-1:0] in_row_q, in_row_d;
  logic [RRW-1:0] in_ring_q, in_ring_d, out_ring_q, out_ring_d;
  logic [IPW-1:0] in_pos_q, in_pos_d;
  logic [OW-1:0]  out_idx_q, out_idx_d;
  logic           incell, drop, accept, step, emit, last;

  logic              s1_valid_q, s1_wall_q, s1_row0_q, s1_byp_q, s1_emit_q, s1_last_q;
  logic [CW-1:0]     s1_col_q, s1_ocol_q;
  logic signed [7:0] s1_cell_q;

  assign in_ready_o = ((LW+1)'(q_level_i) + (LW+1)'(s1_valid_q)) < (LW+1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i & in_ready_o;
  assign incell     = in_row_q < IRW'(h_q);
  assign drop       = incell & op_i;
  assign step       = accept & ~drop;
  assign emit       = in_pos_q >= d_q;
  assign last       = emit && (out_idx_q == totm1_q);

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_ring_d  = in_ring_q;
    in_pos_d   = in_pos_q;
    out_idx_d  = out_idx_q;
    out_col_d  = out_col_q;
    out_ring_d = out_ring_q;
    if (cfg_hit || (step && last)) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_ring_d  = '0;
      in_pos_d   = '0;
      out_idx_d  = '0;
      out_col_d  = '0;
      out_ring_d = '0;
    end else if (step) begin
      in_pos_d = in_pos_q + 1'b1;
      if (in_col_q == CW'(w_q - 1'b1)) begin
        in_col_d  = '0;
        in_row_d  = in_row_q + 1'b1;
        in_ring_d = (in_ring_q == RRW'(NR - 1)) ? '0 : in_ring_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (emit) begin
        out_idx_d = out_idx_q + 1'b1;
        if (out_col_q == CW'(w_q - 1'b1)) begin
          out_col_d  = '0;
          out_ring_d = (out_ring_q == RRW'(NR - 1)) ? '0 : out_ring_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      in_pos_q   <= '0;
      out_idx_q  <= '0;
      out_col_q  <= '0;
      out_ring_q <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_ring_q  <= in_ring_d;
      in_pos_q   <= in_pos_d;
      out_idx_q  <= out_idx_d;
      out_col_q  <= out_col_d;
      out_ring_q <= out_ring_d;
    end
  end

  // line store of original cells, ring of rows
  logic signed [7:0] cell_mem [CDEP];
  logic signed [7:0] cell_rd_q;

  always_ff @(posedge clk_i) begin
    if (step && incell) begin
      cell_mem[{in_ring_q, in_col_q}] <= cell_i;
    end
    if (step) begin
      cell_rd_q <= cell_mem[{out_ring_q, out_col_q}];
    end
  end

  // rows since the last wall, one counter per column
  logic [CNTW-1:0] cnt_mem [MAX_WIDTH];
  logic [CNTW-1:0] cnt_rd_q, cnt_last_q, cnt_old, cnt_new;

  // stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_wall_q <= incell && (cell_i == CELL_WALL);
      s1_row0_q <= (in_row_q == '0);
      // a column read right after its own write (single-column grid)
      s1_byp_q  <= s1_valid_q && (s1_col_q == in_col_q);
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_col_q  <= in_col_q;
      s1_ocol_q <= out_col_q;
      s1_cell_q <= cell_i;
      cnt_rd_q  <= cnt_mem[in_col_q];
    end
    if (s1_valid_q) begin
      cnt_mem[s1_col_q] <= cnt_new;
      cnt_last_q        <= cnt_new;
    end
  end

  always_comb begin
    cnt_old = s1_byp_q ? cnt_last_q : cnt_rd_q;
    if (s1_wall_q) begin
      cnt_new = '0;
    end else if (s1_row0_q || (cnt_old >= CNTW'(CNT_SAT))) begin
      cnt_new = CNTW'(CNT_SAT);
    end else begin
      cnt_new = cnt_old + 1'b1;
    end
  end

  assign push_o      = s1_valid_q;
  assign item_o.emit = s1_emit_q;
  assign item_o.last = s1_last_q;
  // wall within the radius above or below, for the row radius lines up
  assign item_o.vbit = cnt_new <= CNTW'({r_q, 1'b0});
  // with no radius the cell leaves on the step that brings it in
  assign item_o.occ  = (r_q == '0) ? s1_cell_q : cell_rd_q;
  assign col_o       = s1_ocol_q;
  assign geo_w_o     = w_q;
  assign geo_r_o     = r_q;
  assign geo_m_o     = m_q;

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last) |=> (out_idx_q == '0 && in_pos_q == '0 && in_row_q == '0))
    else $error("frame counters not cleared after last cell");

endmodule

FILE: src/owi_back.sv
// back part: horizontal window over the column wall bits and the output register
module owi_back #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  output logic                             q_pop_o,
  input  owi_pkg::owi_item_t               item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     col_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   geo_w_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]  geo_r_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]  geo_m_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [7:0]                out_cell_o,
  output logic                             out_last_o
);
  import owi_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned NT = 2 * MAX_RADIUS + 1;
  localparam int unsigned XW = CW + 7;

  logic [NT-1:0]     win_q, win_new;
  logic [RW:0]       span;
  logic              hit;
  logic signed [XW-1:0] off;
  logic              out_valid_q;
  logic signed [7:0] out_cell_q, cell_res;
  logic              out_last_q;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign win_new = {win_q[NT-2:0], item_i.vbit};
  assign span    = (RW+1)'(geo_m_i) + (RW+1)'(geo_r_i);

  // tap j holds the column bit of output column + m - j
  always_comb begin
    hit = 1'b0;
    off = '0;
    for (int j = 0; j < NT; j++) begin
      off = $signed(XW'(col_i)) + $signed(XW'(geo_m_i)) - $signed(XW'(j));
      if ((int'(span) >= j) && (off >= 0) && (off < $signed(XW'(geo_w_i))) && win_new[j]) begin
        hit = 1'b1;
      end
    end
  end

  assign cell_res = (((item_i.occ == CELL_FREE) || (item_i.occ == CELL_UNKNOWN)) &&
                     (geo_r_i != '0) && hit) ? CELL_INFLATED : item_i.occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        win_q <= win_new;
      end
      if (q_pop_o && item_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && item_i.emit) begin
      out_cell_q <= cell_res;
      out_last_q <= item_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_cell_o  = out_cell_q;
  assign out_last_o  = out_last_q;

  a_window_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(win_q))
    else $error("window moved while output stalled");

endmodule

FILE: src/occupancy_wall_inflation.sv
// top level of the occupancy wall inflation block
// Cells of an occupancy grid enter in raster order on the s_axis channel: tdata holds
// the 8-bit signed cell, tuser the op bit (0 cell, 1 flush tick). Results leave on
// m_axis: tdata holds the cell after inflation, tlast marks the final cell of a frame.
// Free or unknown cells that have a wall (100) inside the square of the configured
// radius become -56; everything else passes unchanged.
// Throughput is one item per cycle unless m_axis stalls. A cell leaves on the step
// that brings in the cell R rows and min(R, W-1) columns after it, then passes three
// register stages (line store read, queue, output register). After the last row has
// been sent, R*W + min(R, W-1) flush ticks drain the frame; flush ticks before that
// are ignored. The cfg port writes grid width, grid height and radius (indexes 0,
// 1, 2); any such write restarts the frame. Reset restores 1024 x 1024 with radius 4,
// no clearing pass is needed. When m_axis stalls, the queue fills and s_axis_tready
// drops after a few items; no result is lost.
module occupancy_wall_inflation #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RADIUS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [owi_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [owi_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] cell_in
  input  logic                       s_axis_tuser,  // [0] op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [7:0] cell_out
  output logic                       m_axis_tlast
);
  import owi_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned IW = $bits(owi_item_t);
  localparam int unsigned QW = IW + CW;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

  owi_item_t         f_item, b_item;
  logic [CW-1:0]     f_col, b_col;
  logic              push, pop, q_valid;
  logic [QW-1:0]     q_data;
  logic [LW-1:0]     q_level;
  logic [WW-1:0]     geo_w;
  logic [RW-1:0]     geo_r, geo_m;
  logic signed [7:0] out_cell;

  owi_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_RADIUS  (MAX_RADIUS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .cell_i     ($signed(s_axis_tdata)),
    .q_level_i  (q_level),
    .push_o     (push),
    .item_o     (f_item),
    .col_o      (f_col),
    .geo_w_o    (geo_w),
    .geo_r_o    (geo_r),
    .geo_m_o    (geo_m)
  );

  owi_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_col, f_item}),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .level_o (q_level)
  );

  assign b_item = owi_item_t'(q_data[IW-1:0]);
  assign b_col  = q_data[QW-1:IW];

  owi_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (pop),
    .item_i      (b_item),
    .col_i       (b_col),
    .geo_w_i     (geo_w),
    .geo_r_i     (geo_r),
    .geo_m_i     (geo_m),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cell_o  (out_cell),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_cell;

endmodule

FILE: tb/owi_checker.sv
// checker for the occupancy wall inflation block: predicts every result and compares it
module owi_checker
  import owi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IW-1:0]   cfg_idx_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [7:0]          m_axis_tdata,
  input  logic                m_axis_tlast,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  result_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_ROWS = 18;
  localparam int unsigned WIDTH_MAX = 1024;
  localparam int unsigned HEIGHT_MAX = 1024;
  localparam int unsigned RADIUS_MAX = 8;

  typedef struct {
    logic signed [7:0] occ;
    logic              last;
  } cell_result_t;

  cell_result_t expected_cells[$];

  logic [CFG_DW-1:0]   width_q, height_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [7:0]          cell_ring[RING_ROWS][WIDTH_MAX];
  int unsigned         in_col, in_row, out_idx;

  assign pending_o = expected_cells.size();

  initial begin
    foreach (cell_ring[r, c]) cell_ring[r][c] = '0;
  end

  function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic inflate_step(input logic op, input logic [7:0] occ);
    int unsigned  w, h, rad, total, lag, pos, orow, ocol, r0, r1, c0, c1;
    logic [7:0]   v;
    bit           hit;
    cell_result_t res;
    w = clip_dim(width_q, WIDTH_MAX);
    h = clip_dim(height_q, HEIGHT_MAX);
    rad = (radius_q > RADIUS_MAX) ? RADIUS_MAX : radius_q;
    total = w * h;
    lag = rad * w + ((rad < w - 1) ? rad : w - 1);
    hit = 1'b0;
    if (in_row < h) begin
      // flush ticks inside the frame are dropped
      if (op) return;
      cell_ring[in_row % RING_ROWS][in_col] = occ;
    end
    pos = in_row * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos < lag) return;
    orow = out_idx / w;
    ocol = out_idx % w;
    v = cell_ring[orow % RING_ROWS][ocol];
    if ((v == CELL_FREE || v == CELL_UNKNOWN) && rad != 0) begin
      r0 = (orow >= rad) ? orow - rad : 0;
      r1 = (orow + rad < h) ? orow + rad : h - 1;
      c0 = (ocol >= rad) ? ocol - rad : 0;
      c1 = (ocol + rad < w) ? ocol + rad : w - 1;
      for (int unsigned y = r0; y <= r1; y++)
        for (int unsigned x = c0; x <= c1; x++)
          if (cell_ring[y % RING_ROWS][x] == CELL_WALL) hit = 1'b1;
      if (hit) v = CELL_INFLATED;
    end
    res.occ = v;
    res.last = (out_idx == total - 1);
    expected_cells = {expected_cells, res};
    if (out_idx == total - 1) begin
      in_col = 0;
      in_row = 0;
      out_idx = 0;
    end else begin
      out_idx++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t exp_cell;
    if (!rst_ni) begin
      width_q <= CFG_DW'(GRID_WIDTH_RST);
      height_q <= CFG_DW'(GRID_HEIGHT_RST);
      radius_q <= RADIUS_W'(INFLATE_RADIUS_RST);
      in_col = 0;
      in_row = 0;
      out_idx = 0;
      fail_cnt_o <= 0;
      result_cnt_o <= 0;
      expected_cells.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt_o <= result_cnt_o + 1;
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected result cell=%0d last=%0b", $time,
                   $signed(m_axis_tdata), m_axis_tlast);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_cell = expected_cells.pop_front();
          if (m_axis_tdata !== exp_cell.occ || m_axis_tlast !== exp_cell.last) begin
            $display("%0t: mismatch expected cell=%0d last=%0b actual cell=%0d last=%0b",
                     $time, exp_cell.occ, exp_cell.last, $signed(m_axis_tdata),
                     m_axis_tlast);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_WIDTH:     width_q <= cfg_data_i;
          REG_GRID_HEIGHT:    height_q <= cfg_data_i;
          REG_INFLATE_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
          default: ;
        endcase
        if (cfg_idx_i inside {REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_INFLATE_RADIUS}) begin
          in_col = 0;
          in_row = 0;
          out_idx = 0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) inflate_step(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

FILE: tb/occupancy_wall_inflation_test.sv
// stimulus and verdict for the occupancy wall inflation block
module occupancy_wall_inflation_test;
  import owi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       OP_CELL = 1'b0;
  localparam logic       OP_FLUSH = 1'b1;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 600000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]   cfg_idx_i = '0;
  logic [CFG_DW-1:0]   cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  int                  fail_cnt, pending, result_cnt;
  int                  cycles = 0;
  int                  cell_items = 0;
  int                  frames = 0;
  bit                  steady_send = 1'b0;
  bit                  steady_recv = 1'b0;
  int unsigned         eff_w = 1024, eff_h = 1024, eff_r = 4;

  always #10 clk_i = ~clk_i;

  occupancy_wall_inflation u_top (.*);

  owi_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .result_cnt_o(result_cnt)
  );

  always @(negedge clk_i)
    m_axis_tready <= steady_recv || ($urandom_range(99) >= 27);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] occ);
    @(negedge clk_i);
    while (!steady_send && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= occ;
    do @(posedge clk_i); while (!s_axis_tready);
    cell_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // cells that produce nothing may still be in the pipeline
    repeat (10) @(negedge clk_i);
  endtask

  function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DW'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:     eff_w = clip_dim(data & 11'h7ff, 1024);
      REG_GRID_HEIGHT:    eff_h = clip_dim(data & 11'h7ff, 1024);
      REG_INFLATE_RADIUS: eff_r = ((data & 4'hf) > 8) ? 8 : (data & 4'hf);
      default: ;
    endcase
  endtask

  function automatic logic [7:0] rand_cell();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return CELL_FREE;
    if (pick < 60) return CELL_UNKNOWN;
    if (pick < 68) return CELL_WALL;
    return 8'($urandom);
  endfunction

  // one full frame and its drain, with optional stray flushes and cells in the drain
  task automatic run_frame(input bit noisy);
    int unsigned lag;
    lag = eff_r * eff_w + ((eff_r < eff_w - 1) ? eff_r : eff_w - 1);
    for (int unsigned i = 0; i < eff_w * eff_h; i++) begin
      if (noisy && $urandom_range(19) == 0) send_item(OP_FLUSH, 8'($urandom));
      send_item(OP_CELL, rand_cell());
    end
    for (int unsigned i = 0; i < lag; i++)
      send_item((noisy && $urandom_range(9) == 0) ? OP_CELL : OP_FLUSH, 8'($urandom));
    frames++;
  endtask

  task automatic set_grid(input int unsigned w, input int unsigned h, input int unsigned r);
    wait_idle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_INFLATE_RADIUS, r);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, disabled inflation, clamping, abort and unknown register
    set_grid(1, 1, 0);
    send_item(OP_FLUSH, 8'h00);
    send_item(OP_CELL, CELL_FREE);
    set_grid(3, 3, 1);
    send_item(OP_CELL, 8'h80);
    send_item(OP_CELL, 8'h7f);
    send_item(OP_CELL, CELL_WALL);
    send_item(OP_CELL, CELL_UNKNOWN);
    // abort partial frame by a register write
    wait_idle();
    write_reg(REG_INFLATE_RADIUS, 1);
    run_frame(1'b1);
    wait_idle();
    write_reg(REG_UNUSED, 5);
    run_frame(1'b0);
    set_grid(0, 0, 15);
    run_frame(1'b1);
    set_grid(1500, 1, 0);
    run_frame(1'b0);
    set_grid(5, 4, 8);
    run_frame(1'b1);

    steady_send = 1'b1;
    steady_recv = 1'b1;
    set_grid(12, 6, 2);
    run_frame(1'b0);
    steady_send = 1'b0;
    steady_recv = 1'b0;

    while (cell_items < 1950) begin
      if ($urandom_range(3) == 0) begin
        set_grid($urandom_range(1, 24), $urandom_range(1, 12), $urandom_range(0, 9));
      end else begin
        wait_idle();
      end
      run_frame($urandom_range(3) == 0);
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    $display("covered %0d frames, %0d input transactions and %0d checked results",
             frames, cell_items, result_cnt);
    $display("grid sizes from 1x1 up to the width limit, radius 0 to 8, aborts and drain noise");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/owi_pkg.sv
src/owi_fifo.sv
src/owi_front.sv
src/owi_back.sv
src/occupancy_wall_inflation.sv
tb/owi_checker.sv
tb/occupancy_wall_inflation_test.sv
